/* hdl/gsc_pkg.sv */
// Shared constants for the Gaussian strip charge-sharing unit.
// Holds port widths, CSR register indexes and fixed-point constants.
// No dependencies.
package gsc_pkg;

   // CSR port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // CSR register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_FIRST_STRIP = 2'd0;
   localparam logic [1:0] REG_STRIP_COUNT = 2'd1;
   localparam logic [1:0] REG_EDGE_SCALE  = 2'd2;

   // Field widths
   localparam int FIRST_W    = 10;
   localparam int COUNT_W    = 7;
   localparam int SCALE_W    = 16;
   localparam int POS_W      = 19;
   localparam int CHARGE_W   = 16;
   localparam int INDEX_W    = 11;
   localparam int PHI_W      = 17;
   localparam int DIFF_W     = 20;
   localparam int PROD_W     = POS_W + PHI_W;

   // Stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   // z is Q20; the table spans |z| in [0, 4), i.e. below 2**22
   localparam int Z_SPAN_W = 22;

   // Fixed-point constants
   localparam logic [PHI_W-1:0] PHI_ONE  = 17'h1_0000;
   localparam logic [63:0]      Q32_ONE  = 64'h1_0000_0000;
   localparam logic [63:0]      PHI_HALF = 64'd32768;

endpackage

/* hdl/gaussian_strip_charge_sharing_unit.sv */
// Top level of the Gaussian strip charge-sharing unit.
// One shared multiplier under a small sequencer; the CDF ROM is built at elaboration.
// Depends on gsc_pkg.
//
// Each hit walks its run strip by strip; each strip edge needs the shared multiplier
// for z and a registered CDF ROM read, and each strip needs the multiplier again for
// its charge share. A new request is taken only once the previous run has finished.
// A stalled result holds the sequencer only when the output register is still full.
// Reset: synchronous, active high; clears the sequencer and output valid and loads
// first_strip 0, strip_count 64, edge_scale 4096. The CDF ROM is constant.
module gaussian_strip_charge_sharing_unit #(
   parameter int MAX_STRIPS        = 64,
   parameter int CDF_TABLE_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [18:0] hit_pos, [34:19] hit_charge, [39:35] zero
   input  logic [gsc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [10:0] strip_index, [26:11] strip_charge, [31:27] zero
   output logic [gsc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // Configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gsc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gsc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import gsc_pkg::*;

   localparam int AW          = (CDF_TABLE_ENTRIES > 1) ? $clog2(CDF_TABLE_ENTRIES) : 1;
   localparam int ADDR_PROD_W = Z_SPAN_W + $clog2(CDF_TABLE_ENTRIES + 1);
   localparam int CW          = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
   localparam int SAMPLES     = CDF_TABLE_ENTRIES * 4;
   localparam logic [63:0] SAMPLE_DEN = 64'(SAMPLES) * 64'(SAMPLES);

   typedef logic [15:0] cdf_rom_type [CDF_TABLE_ENTRIES];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZMUL,
      ST_LOOK,
      ST_PHI,
      ST_QMUL
   } state_type;

   // exp(-f) in Q32 for f in [0, 1), alternating series of 20 terms
   function automatic logic [63:0] exp_frac(input logic [63:0] f);
      logic [63:0] pos_sum;
      logic [63:0] neg_sum;
      logic [63:0] term;
      pos_sum = Q32_ONE;
      neg_sum = '0;
      term    = Q32_ONE;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k[0]) begin
            neg_sum = neg_sum + term;
         end else begin
            pos_sum = pos_sum + term;
         end
      end
      return pos_sum - neg_sum;
   endfunction

   // exp(-t*t) in Q32 at sample j, t = 4*j/SAMPLES
   function automatic logic [63:0] gauss_sample(input logic [63:0] j,
                                                input logic [63:0] e_inv);
      logic [63:0] num;
      logic [63:0] whole;
      logic [63:0] frac;
      logic [63:0] r;
      num   = 64'd16 * j * j;
      whole = num / SAMPLE_DEN;
      frac  = ((num % SAMPLE_DEN) << 32) / SAMPLE_DEN;
      r     = exp_frac(frac);
      for (int i = 0; i < 16; i++) begin
         if (64'(i) < whole) begin
            r = (r * e_inv) >> 32;
         end
      end
      return r;
   endfunction

   // Restoring shift-subtract quotient n / d, for quotients below 2**16
   function automatic logic [15:0] shift_div(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] rem;
      logic [15:0] q;
      rem = n;
      q   = '0;
      for (int b = 15; b >= 0; b--) begin
         if (rem >= (d << b)) begin
            rem  = rem - (d << b);
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Build 0.5*(1+erf) table by Simpson integration, Q0.16
   function automatic cdf_rom_type build_cdf_rom();
      cdf_rom_type rom;
      logic [63:0] cum [CDF_TABLE_ENTRIES];
      logic [63:0] half;
      logic [63:0] e_inv;
      logic [63:0] acc;
      logic [63:0] b;
      half  = exp_frac(Q32_ONE >> 1);
      e_inv = (half * half) >> 32;
      acc   = '0;
      for (int k = 0; k < CDF_TABLE_ENTRIES; k++) begin
         b      = 64'(k) * 64'd4;
         cum[k] = acc;
         acc    = acc + gauss_sample(b, e_inv)
                      + 64'd4 * gauss_sample(b + 64'd1, e_inv)
                      + 64'd2 * gauss_sample(b + 64'd2, e_inv)
                      + 64'd4 * gauss_sample(b + 64'd3, e_inv)
                      + gauss_sample(b + 64'd4, e_inv);
      end
      for (int k = 0; k < CDF_TABLE_ENTRIES; k++) begin
         rom[k] = 16'(PHI_HALF + 64'(shift_div(cum[k] << 15, acc)));
      end
      return rom;
   endfunction

   localparam cdf_rom_type CDF_ROM = build_cdf_rom();

   // Configuration registers
   logic [FIRST_W-1:0]  first_strip_ff;
   logic [COUNT_W-1:0]  strip_count_ff;
   logic [SCALE_W-1:0]  edge_scale_ff;

   // Sequencer and datapath registers
   state_type           state_ff;
   logic [POS_W-1:0]    hit_ff;
   logic [CHARGE_W-1:0] charge_ff;
   logic [POS_W-1:0]    edge_ff;
   logic [CW-1:0]       offset_ff;
   logic                first_edge_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                neg_ff;
   logic                sat_ff;
   logic [15:0]         rom_data_ff;
   logic [PHI_W-1:0]    phi_lo_ff;
   logic [PHI_W-1:0]    phi_hi_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [CHARGE_W-1:0] rsp_charge_ff;
   logic                rsp_last_ff;

   logic                   req_accept;
   logic                   csr_write;
   logic [COUNT_W-1:0]     eff_count;
   logic [DIFF_W-1:0]      edge_diff;
   logic                   diff_neg;
   logic [DIFF_W-1:0]      diff_abs;
   logic [POS_W-1:0]       mul_a;
   logic [PHI_W-1:0]       mul_b;
   logic [PROD_W-1:0]      mul_p;
   logic [ADDR_PROD_W-1:0] addr_prod;
   logic [AW-1:0]          rom_addr;
   logic [PHI_W-1:0]       phi_pos;
   logic [PHI_W-1:0]       phi_val;
   logic [PHI_W-1:0]       share;
   logic                   rsp_load;
   logic                   last_in;
   logic [INDEX_W-1:0]     strip_index;
   logic [POS_W-1:0]       first_edge_q8;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Clamp the run length
   assign eff_count = (strip_count_ff > COUNT_W'(MAX_STRIPS)) ? COUNT_W'(MAX_STRIPS)
                                                             : strip_count_ff;

   // Lower edge of the first strip in Q8: first*256 - 128
   assign first_edge_q8 = {first_strip_ff[FIRST_W-1], first_strip_ff, 8'h00} - 19'd128;

   // Edge minus hit, exact in Q8, split into sign and magnitude
   assign edge_diff = {edge_ff[POS_W-1], edge_ff} - {hit_ff[POS_W-1], hit_ff};
   assign diff_neg  = edge_diff[DIFF_W-1];
   assign diff_abs  = diff_neg ? (~edge_diff + 20'd1) : edge_diff;

   // Charge share of this strip, clipped at zero
   assign share = (phi_hi_ff > phi_lo_ff) ? (phi_hi_ff - phi_lo_ff) : '0;

   // Shared multiplier: z = |d|*scale, or charge*share
   always_comb begin
      mul_a = diff_abs[POS_W-1:0];
      mul_b = {1'b0, edge_scale_ff};
      if (state_ff == ST_QMUL) begin
         mul_a = POS_W'(charge_ff);
         mul_b = share;
      end
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // ROM address = floor(z * entries / 4.0)
   assign addr_prod = ADDR_PROD_W'(prod_ff[Z_SPAN_W-1:0]) * ADDR_PROD_W'(CDF_TABLE_ENTRIES);
   assign rom_addr  = addr_prod[Z_SPAN_W +: AW];

   // Saturate at the table end, mirror for negative z (z = 0 reads entry 0 either way)
   assign phi_pos = sat_ff ? PHI_ONE : {1'b0, rom_data_ff};
   assign phi_val = neg_ff ? (PHI_ONE - phi_pos) : phi_pos;

   assign strip_index = {first_strip_ff[FIRST_W-1], first_strip_ff} + INDEX_W'(offset_ff);
   assign last_in     = (COUNT_W'(offset_ff) + COUNT_W'(1)) == eff_count;
   assign rsp_load    = (state_ff == ST_QMUL) && (!rsp_valid_ff || rsp_tready);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_strip_ff <= '0;
         strip_count_ff <= 7'd64;
         edge_scale_ff  <= 16'd4096;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_FIRST_STRIP: first_strip_ff <= csr_pwdata[FIRST_W-1:0];
            REG_STRIP_COUNT: strip_count_ff <= csr_pwdata[COUNT_W-1:0];
            REG_EDGE_SCALE:  edge_scale_ff  <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_FIRST_STRIP: csr_prdata = CSR_DATA_W'(first_strip_ff);
         REG_STRIP_COUNT: csr_prdata = CSR_DATA_W'(strip_count_ff);
         REG_EDGE_SCALE:  csr_prdata = CSR_DATA_W'(edge_scale_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Sequencer, datapath and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         first_edge_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one replaces it
         if (rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  hit_ff        <= req_tdata[POS_W-1:0];
                  charge_ff     <= req_tdata[POS_W +: CHARGE_W];
                  edge_ff       <= first_edge_q8;
                  offset_ff     <= '0;
                  first_edge_ff <= 1'b1;
                  if (eff_count != '0) begin
                     state_ff <= ST_ZMUL;
                  end
               end
            end
            ST_ZMUL: begin
               prod_ff  <= mul_p;
               neg_ff   <= diff_neg;
               state_ff <= ST_LOOK;
            end
            ST_LOOK: begin
               rom_data_ff <= CDF_ROM[rom_addr];
               sat_ff      <= |prod_ff[PROD_W-1:Z_SPAN_W];
               state_ff    <= ST_PHI;
            end
            ST_PHI: begin
               // Shift the edge CDF pair and advance to the next edge
               phi_lo_ff     <= phi_hi_ff;
               phi_hi_ff     <= phi_val;
               edge_ff       <= edge_ff + 19'd256;
               first_edge_ff <= 1'b0;
               state_ff      <= first_edge_ff ? ST_ZMUL : ST_QMUL;
            end
            ST_QMUL: begin
               // Hold until the output register is free
               if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_index_ff  <= strip_index;
                  rsp_charge_ff <= mul_p[16 +: CHARGE_W];
                  rsp_last_ff   <= last_in;
                  offset_ff     <= offset_ff + CW'(1);
                  state_ff      <= last_in ? ST_IDLE : ST_ZMUL;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_charge_ff, rsp_index_ff};

   // A request with a non-empty run starts on its lower edge
   a_start_edge: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (eff_count != '0)) |=> (state_ff == ST_ZMUL) && first_edge_ff)
      else $error("run did not start on the first edge");

   // The final strip releases the sequencer and is marked
   a_last_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_in) |=> (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("last strip did not close the run");

   // A share is only formed once both edges are known
   a_share_edges: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QMUL) |-> !first_edge_ff)
      else $error("share formed without a lower edge");

   // The CDF value is taken only from a registered ROM read
   a_rom_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PHI) |-> ($past(state_ff) == ST_LOOK))
      else $error("CDF value used before ROM read");

endmodule

/* tb/gaussian_strip_charge_sharing_unit_test.sv */
// Self-checking bench for the Gaussian strip charge-sharing unit: hit requests in,
// per-strip charge shares out, checked against an in-bench CDF table and share predictor.
// Depends on gsc_pkg and gaussian_strip_charge_sharing_unit.
module gaussian_strip_charge_sharing_unit_test;
   import gsc_pkg::*;

   localparam int CDF_N          = 1024;
   localparam int MAX_RUN        = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int NUM_CASES      = 21;
   localparam int RANDOM_PHASES  = 8;
   localparam int HITS_PER_PHASE = 29;
   localparam int QUIET_CYCLES   = 300;
   localparam int HOLD_CYCLES    = 500;
   localparam int DRAIN_CYCLES   = 300;
   localparam int LIMIT_CYCLES   = 1000000;
   localparam int SHOWN_ERRORS   = 10;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_QUARTER, READY_PERIODIC} ready_pattern_type;

   // One expected strip share
   typedef struct packed {
      logic [INDEX_W-1:0]  idx;
      logic [CHARGE_W-1:0] chg;
      logic                last;
   } strip_share_type;

   // One directed hit; typed rows carry the share every strip must see
   typedef struct packed {
      logic [FIRST_W-1:0]  first;
      logic [COUNT_W-1:0]  count;
      logic [SCALE_W-1:0]  scale;
      logic [POS_W-1:0]    pos;
      logic [CHARGE_W-1:0] charge;
      logic                typed;
      logic [CHARGE_W-1:0] share;
   } hit_case_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Register mirror used by the share predictor
   logic [FIRST_W-1:0] cfg_first;
   logic [COUNT_W-1:0] cfg_count;
   logic [SCALE_W-1:0] cfg_scale;

   longint unsigned cdf_rom [CDF_N];
   strip_share_type share_q [$];
   hit_case_type    hit_cases [NUM_CASES];
   int              errors = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   bit              hold_request = 1'b0;
   bit              hold_done = 1'b0;

   gaussian_strip_charge_sharing_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exp(-f) in Q32 for f in [0, 1), alternating 20-term series
   function automatic longint unsigned exp_neg_frac(longint unsigned f);
      longint unsigned pos_sum, neg_sum, term;
      pos_sum = 64'h1_0000_0000;
      neg_sum = 0;
      term = pos_sum;
      for (longint unsigned k = 1; k <= 20; k++) begin
         term = ((term * f) >> 32) / k;
         if (k[0])
            neg_sum += term;
         else
            pos_sum += term;
      end
      return pos_sum - neg_sum;
   endfunction

   // exp(-t*t) in Q32 at sample j of the Simpson grid
   function automatic longint unsigned gauss_q32(longint unsigned j, longint unsigned e_inv);
      longint unsigned den, num, whole, frac, r;
      den = longint'(CDF_N * 4) * longint'(CDF_N * 4);
      num = 64'd16 * j * j;
      whole = num / den;
      frac = ((num % den) << 32) / den;
      r = exp_neg_frac(frac);
      for (longint unsigned i = 0; i < whole; i++)
         r = (r * e_inv) >> 32;
      return r;
   endfunction

   // Fill the half-range CDF table, Q0.16 around 0.5
   function automatic void build_cdf_table();
      longint unsigned part_sum [CDF_N];
      longint unsigned half, e_inv, acc, b;
      half = exp_neg_frac(64'h8000_0000);
      e_inv = (half * half) >> 32;
      acc = 0;
      for (int k = 0; k < CDF_N; k++) begin
         b = longint'(k) * 4;
         part_sum[k] = acc;
         acc += gauss_q32(b, e_inv) + 4 * gauss_q32(b + 1, e_inv)
              + 2 * gauss_q32(b + 2, e_inv) + 4 * gauss_q32(b + 3, e_inv)
              + gauss_q32(b + 4, e_inv);
      end
      for (int k = 0; k < CDF_N; k++)
         cdf_rom[k] = 64'd32768 + ((part_sum[k] << 15) / acc);
   endfunction

   // CDF at a strip boundary, offset from the hit given in Q8
   function automatic longint unsigned edge_cdf(longint offset);
      longint unsigned mag, z, p;
      bit neg;
      neg = offset < 0;
      mag = neg ? -offset : offset;
      z = mag * cfg_scale;
      if (z >= (64'd4 << 20))
         p = 64'd65536;
      else
         p = cdf_rom[(z * CDF_N) >> 22];
      if (z == 0)
         return cdf_rom[0];
      return neg ? 64'd65536 - p : p;
   endfunction

   // Queue the share of every strip in the run for one accepted hit
   function automatic void spread_hit(logic [POS_W-1:0] pos, logic [CHARGE_W-1:0] charge,
                                      bit typed, logic [CHARGE_W-1:0] share);
      longint hit, s;
      longint unsigned hi_p, lo_p, diff, prod;
      int run;
      strip_share_type e;
      hit = longint'($signed(pos));
      run = (cfg_count > MAX_RUN) ? MAX_RUN : int'(cfg_count);
      for (int i = 0; i < run; i++) begin
         s = longint'($signed(cfg_first)) + i;
         hi_p = edge_cdf(s * 256 + 128 - hit);
         lo_p = edge_cdf(s * 256 - 128 - hit);
         diff = (hi_p > lo_p) ? hi_p - lo_p : 0;
         prod = (charge * diff) >> 16;
         e.idx = s[INDEX_W-1:0];
         e.chg = typed ? share : prod[CHARGE_W-1:0];
         e.last = (i + 1 == run);
         share_q.push_back(e);
      end
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= SHOWN_ERRORS)
         $display("%s", msg);
   endtask

   // Two-phase register write; update the mirror when the write lands
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_FIRST_STRIP: cfg_first = value[FIRST_W-1:0];
         REG_STRIP_COUNT: cfg_count = value[COUNT_W-1:0];
         REG_EDGE_SCALE:  cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drop the request line, drain all shares, then let the sequencer go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (share_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Program a run, junk in the upper write bits, then read the registers back
   task automatic apply_config(input logic [FIRST_W-1:0] first, input logic [COUNT_W-1:0] count,
                               input logic [SCALE_W-1:0] scale);
      logic [CSR_DATA_W-1:0] wdata, rdata;
      settle();
      wdata = $urandom;
      wdata[FIRST_W-1:0] = first;
      csr_write(REG_FIRST_STRIP, wdata);
      wdata = $urandom;
      wdata[COUNT_W-1:0] = count;
      csr_write(REG_STRIP_COUNT, wdata);
      wdata = $urandom;
      wdata[SCALE_W-1:0] = scale;
      csr_write(REG_EDGE_SCALE, wdata);
      // unmapped register: must leave the run untouched
      csr_write(REG_UNUSED, $urandom);
      csr_read(REG_FIRST_STRIP, rdata);
      if (rdata[FIRST_W-1:0] !== cfg_first)
         flag_error($sformatf("first_strip read exp %h got %h", cfg_first, rdata));
      csr_read(REG_STRIP_COUNT, rdata);
      if (rdata[COUNT_W-1:0] !== cfg_count)
         flag_error($sformatf("strip_count read exp %h got %h", cfg_count, rdata));
      csr_read(REG_EDGE_SCALE, rdata);
      if (rdata[SCALE_W-1:0] !== cfg_scale)
         flag_error($sformatf("edge_scale read exp %h got %h", cfg_scale, rdata));
   endtask

   // Offer one hit request in bursts with random gaps; predict on acceptance
   task automatic send_hit(input logic [POS_W-1:0] pos, input logic [CHARGE_W-1:0] charge,
                           input bit typed, input logic [CHARGE_W-1:0] share);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata <= {{(REQ_TDATA_W - POS_W - CHARGE_W){1'b0}}, charge, pos};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      spread_hit(pos, charge, typed, share);
      @(negedge clock);
   endtask

   // Result side: stall on a rotating pattern, with one long hold-off
   initial begin : receiver
      ready_pattern_type pattern;
      int left, tick;
      pattern = READY_ALWAYS;
      left = 0;
      tick = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (left == 0) begin
               pattern = ready_pattern_type'($urandom_range(0, 3));
               left = $urandom_range(16, 64);
            end
            left--;
            case (pattern)
               READY_ALWAYS:  rsp_tready <= 1'b1;
               READY_HALF:    rsp_tready <= 1'($urandom_range(0, 1));
               READY_QUARTER: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:       rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   // Compare each accepted result with the oldest expected share
   always @(posedge clock) begin : result_check
      strip_share_type want;
      logic [INDEX_W-1:0]  got_idx;
      logic [CHARGE_W-1:0] got_chg;
      got_idx = rsp_tdata[INDEX_W-1:0];
      got_chg = rsp_tdata[INDEX_W +: CHARGE_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (share_q.size() == 0) begin
            flag_error($sformatf("unexpected result strip %0d charge %0d",
                                 $signed(got_idx), got_chg));
         end else begin
            want = share_q.pop_front();
            if (got_idx !== want.idx)
               flag_error($sformatf("strip_index exp %0d got %0d",
                                    $signed(want.idx), $signed(got_idx)));
            if (got_chg !== want.chg)
               flag_error($sformatf("strip_charge exp %0d got %0d (strip %0d)",
                                    want.chg, got_chg, $signed(want.idx)));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last_strip exp %0b got %0b (strip %0d)",
                                    want.last, rsp_tlast, $signed(want.idx)));
         end
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[gaussian_strip_charge_sharing_unit] ERROR");
         $finish;
      end
   end

   initial begin
      hit_case_type row;
      logic [FIRST_W-1:0]  first;
      logic [COUNT_W-1:0]  count;
      logic [SCALE_W-1:0]  scale;
      logic [POS_W-1:0]    pos;
      logic [CHARGE_W-1:0] charge;
      int run, off, pos_int;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_first = '0;
      cfg_count = 7'd64;
      cfg_scale = 16'd4096;

      //               first    count  scale        pos          charge     typed share
      hit_cases = '{
         '{10'h000, 7'd64,  16'd4096,  19'd0,       16'd1000,  1'b0, 16'd0},     // reset run
         '{10'h000, 7'd64,  16'd4096,  19'd0,       16'd0,     1'b1, 16'd0},     // no charge
         '{10'h000, 7'd64,  16'd4096,  19'h3FFFF,   16'hFFFF,  1'b0, 16'd0},     // top position
         '{10'h000, 7'd64,  16'd4096,  19'h40000,   16'hFFFF,  1'b0, 16'd0},     // bottom position
         '{10'h000, 7'd64,  16'd4096,  19'h7FFFF,   16'hFFFF,  1'b0, 16'd0},
         '{10'h000, 7'd64,  16'd0,     19'd12345,   16'hFFFF,  1'b1, 16'd0},     // zero scale
         '{10'h000, 7'd64,  16'd0,     19'h40000,   16'hFFFF,  1'b1, 16'd0},
         '{10'h000, 7'd1,   16'hFFFF,  19'd0,       16'hFFFF,  1'b1, 16'hFFFF},  // all in one strip
         '{10'h000, 7'd1,   16'hFFFF,  19'd0,       16'd1,     1'b1, 16'd1},
         '{10'h000, 7'd1,   16'd32768, 19'd0,       16'd12345, 1'b1, 16'd12345}, // exactly at table end
         '{10'h000, 7'd1,   16'd32767, 19'd0,       16'd12345, 1'b0, 16'd0},     // just inside table
         '{10'h200, 7'd64,  16'd4096,  19'h60000,   16'd40000, 1'b0, 16'd0},     // lowest first strip
         '{10'h1FF, 7'd64,  16'd4096,  19'h1FF40,   16'hFFFF,  1'b0, 16'd0},     // highest first strip
         '{10'h000, 7'd0,   16'd4096,  19'd0,       16'd500,   1'b0, 16'd0},     // empty run
         '{10'h000, 7'd127, 16'd4096,  19'd2000,    16'd30000, 1'b0, 16'd0},     // run clamps to max
         '{10'h000, 7'd65,  16'd4096,  19'd8000,    16'd30000, 1'b0, 16'd0},
         '{10'h3FE, 7'd6,   16'd4096,  19'd128,     16'd50000, 1'b0, 16'd0},     // hit on a boundary
         '{10'h3FE, 7'd6,   16'd4096,  19'd0,       16'd50000, 1'b0, 16'd0},
         '{10'h3FE, 7'd6,   16'd1,     19'd0,       16'hFFFF,  1'b0, 16'd0},     // tiny scale
         '{10'h3FE, 7'd6,   16'hFFFF,  19'd300,     16'hFFFF,  1'b0, 16'd0},
         '{10'h3F0, 7'd32,  16'd2048,  19'h7FF00,   16'hFFFF,  1'b0, 16'd0}
      };

      build_cdf_table();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed hits, reprogramming only when the run changes
      for (int n = 0; n < NUM_CASES; n++) begin
         row = hit_cases[n];
         if (row.first != cfg_first || row.count != cfg_count || row.scale != cfg_scale)
            apply_config(row.first, row.count, row.scale);
         send_hit(row.pos, row.charge, row.typed, row.share);
      end

      // Random phases: mostly hits inside the run, some anywhere
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         first = FIRST_W'($urandom);
         case ($urandom_range(0, 3))
            0:       count = COUNT_W'($urandom_range(1, 4));
            1:       count = COUNT_W'($urandom_range(5, 16));
            2:       count = COUNT_W'($urandom_range(17, 64));
            default: count = COUNT_W'($urandom_range(65, 127));
         endcase
         case ($urandom_range(0, 5))
            0:       scale = 16'hFFFF;
            1:       scale = SCALE_W'($urandom_range(1, 255));
            default: scale = SCALE_W'($urandom_range(256, 16384));
         endcase
         if (p == 0) begin
            first = 10'h200;
            count = 7'd64;
         end
         if (p == 1) begin
            first = 10'h1FF;
            count = 7'd127;
            scale = 16'hFFFF;
         end
         apply_config(first, count, scale);
         // back up the result side while hits keep coming
         if (p == 0)
            hold_request = 1'b1;
         run = (count > MAX_RUN) ? MAX_RUN : int'(count);
         for (int k = 0; k < HITS_PER_PHASE; k++) begin
            if ($urandom_range(0, 4) != 0) begin
               off = $urandom_range(0, run - 1);
               pos_int = (int'($signed(first)) + off) * 256 + int'($urandom_range(0, 255)) - 128;
               pos = pos_int[POS_W-1:0];
            end else begin
               pos = POS_W'($urandom);
            end
            case ($urandom_range(0, 7))
               0:       charge = 16'd0;
               1:       charge = 16'hFFFF;
               default: charge = CHARGE_W'($urandom);
            endcase
            send_hit(pos, charge, 1'b0, '0);
         end
      end

      // Drain and report
      req_tvalid <= 1'b0;
      while (share_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[gaussian_strip_charge_sharing_unit] OK");
      else
         $display("[gaussian_strip_charge_sharing_unit] ERROR");
      $finish;
   end

endmodule
